// ===== sv/mtq_pkg.sv =====
// ----------------------------------------------------------------------------
// mtq_pkg
// Shared sizes, codes and controller states of the max-tracking queue.
// ----------------------------------------------------------------------------
package mtq_pkg;

    localparam int DEPTH  = 64;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = ADDR_W + 1;
    localparam int DATA_W = 32;

    typedef enum logic {
        OP_ENQ = 1'b0,
        OP_DEQ = 1'b1
    } op_t;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_REFUSE,
        S_ENQ_SCAN,
        S_ENQ_LOAD,
        S_DEQ_DATA
    } state_t;

endpackage

// ===== sv/mtq_ram.sv =====
// ----------------------------------------------------------------------------
// mtq_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module mtq_ram #(
    parameter int DATA_W = 32,
    parameter int ADDR_W = 6
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data
);

    localparam int WORDS = 1 << ADDR_W;

    logic [DATA_W-1:0] mem [WORDS];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read data holds until the next read is issued.
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== sv/max_tracking_queue.sv =====
// ----------------------------------------------------------------------------
// max_tracking_queue
// A dequeue or a refused request goes from S_IDLE to S_DEQ_DATA or S_REFUSE, which
// registers its result; an enqueue goes to S_ENQ_SCAN, which drops each smaller
// entry of the max store (reloading the tail in S_ENQ_LOAD unless the store is
// empty), then stores the value and registers the result. The input is closed
// while a request is in progress, so none is taken until the last is done; each
// value is displaced at most once. Reset empties the queue at once; no clear pass.
// ----------------------------------------------------------------------------
module max_tracking_queue
    import mtq_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic                     s_operation,
    input  logic signed [DATA_W-1:0] s_value,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic signed [DATA_W-1:0] m_data_out,
    output logic signed [DATA_W-1:0] m_max_value,
    output logic [CNT_W-1:0]         m_fill_count,
    output logic [1:0]               m_status
);

    state_t state_reg, state_next;

    logic [ADDR_W-1:0] head_reg, head_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [ADDR_W-1:0] dq_head_reg, dq_head_next;
    logic [CNT_W-1:0]  dq_count_reg, dq_count_next;

    logic signed [DATA_W-1:0] front_reg, front_next;
    logic signed [DATA_W-1:0] back_reg, back_next;
    logic signed [DATA_W-1:0] val_reg, val_next;
    status_t                  status_reg, status_next;

    logic                     m_valid_reg, m_valid_next;
    logic signed [DATA_W-1:0] m_data_out_reg, m_data_out_next;
    logic signed [DATA_W-1:0] m_max_value_reg, m_max_value_next;
    logic [CNT_W-1:0]         m_fill_count_reg, m_fill_count_next;
    status_t                  m_status_reg, m_status_next;

    logic              fifo_wr_en, fifo_rd_en;
    logic [ADDR_W-1:0] fifo_wr_addr, fifo_rd_addr;
    logic [DATA_W-1:0] fifo_rd_data;

    logic              dq_wr_en, dq_rd_en;
    logic [ADDR_W-1:0] dq_wr_addr, dq_rd_addr;
    logic [DATA_W-1:0] dq_rd_data;

    logic              s_accept;
    logic              out_free;
    logic              back_lt;
    logic              front_leaves;
    logic [CNT_W-1:0]  dq_prev_ofs;

    // Plain ring buffer of queued values.
    mtq_ram #(
        .DATA_W (DATA_W),
        .ADDR_W (ADDR_W)
    ) u_fifo_ram (
        .aclk    (aclk),
        .wr_en   (fifo_wr_en),
        .wr_addr (fifo_wr_addr),
        .wr_data (val_next),
        .rd_en   (fifo_rd_en),
        .rd_addr (fifo_rd_addr),
        .rd_data (fifo_rd_data)
    );

    // Non-increasing deque of candidate maxima; its front is the current max.
    mtq_ram #(
        .DATA_W (DATA_W),
        .ADDR_W (ADDR_W)
    ) u_max_ram (
        .aclk    (aclk),
        .wr_en   (dq_wr_en),
        .wr_addr (dq_wr_addr),
        .wr_data (val_reg),
        .rd_en   (dq_rd_en),
        .rd_addr (dq_rd_addr),
        .rd_data (dq_rd_data)
    );

    assign s_ready   = (state_reg == S_IDLE);
    assign s_accept  = s_valid && s_ready;
    assign out_free  = !m_valid_reg || m_ready;
    assign back_lt   = (dq_count_reg != '0) && (back_reg < val_reg);
    // The oldest entry is in the deque exactly when it equals the deque front.
    assign front_leaves = (front_reg == fifo_rd_data);
    assign dq_prev_ofs = dq_count_reg - CNT_W'(2);

    assign m_valid      = m_valid_reg;
    assign m_data_out   = m_data_out_reg;
    assign m_max_value  = m_max_value_reg;
    assign m_fill_count = m_fill_count_reg;
    assign m_status     = m_status_reg;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_accept) begin
                    if (s_operation == OP_ENQ) begin
                        state_next = (count_reg == CNT_W'(DEPTH)) ? S_REFUSE : S_ENQ_SCAN;
                    end else begin
                        state_next = (count_reg == '0) ? S_REFUSE : S_DEQ_DATA;
                    end
                end
            end
            S_REFUSE: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            S_ENQ_SCAN: begin
                if (back_lt) begin
                    state_next = (dq_count_reg > CNT_W'(1)) ? S_ENQ_LOAD : S_ENQ_SCAN;
                end else if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            S_ENQ_LOAD: begin
                state_next = S_ENQ_SCAN;
            end
            S_DEQ_DATA: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb begin
        head_next     = head_reg;
        count_next    = count_reg;
        dq_head_next  = dq_head_reg;
        dq_count_next = dq_count_reg;
        front_next    = front_reg;
        back_next     = back_reg;
        val_next      = val_reg;
        status_next   = status_reg;

        m_valid_next      = m_valid_reg && !m_ready;
        m_data_out_next   = m_data_out_reg;
        m_max_value_next  = m_max_value_reg;
        m_fill_count_next = m_fill_count_reg;
        m_status_next     = m_status_reg;

        fifo_wr_en   = 1'b0;
        fifo_wr_addr = head_reg + count_reg[ADDR_W-1:0];
        fifo_rd_en   = 1'b0;
        fifo_rd_addr = head_reg;
        dq_wr_en     = 1'b0;
        dq_wr_addr   = dq_head_reg + dq_count_reg[ADDR_W-1:0];
        dq_rd_en     = 1'b0;
        dq_rd_addr   = dq_head_reg + ADDR_W'(1);

        unique case (state_reg)
            S_IDLE: begin
                if (s_accept) begin
                    val_next = s_value;
                    if (s_operation == OP_ENQ) begin
                        if (count_reg == CNT_W'(DEPTH)) begin
                            status_next = ST_FULL;
                        end else begin
                            fifo_wr_en = 1'b1;
                            count_next = count_reg + CNT_W'(1);
                        end
                    end else begin
                        if (count_reg == '0) begin
                            status_next = ST_EMPTY;
                        end else begin
                            // Fetch the oldest entry and the deque entry behind the front.
                            fifo_rd_en = 1'b1;
                            dq_rd_en   = 1'b1;
                            head_next  = head_reg + ADDR_W'(1);
                            count_next = count_reg - CNT_W'(1);
                        end
                    end
                end
            end
            S_REFUSE: begin
                if (out_free) begin
                    m_valid_next      = 1'b1;
                    m_data_out_next   = '0;
                    m_max_value_next  = (count_reg != '0) ? front_reg : '0;
                    m_fill_count_next = count_reg;
                    m_status_next     = status_reg;
                end
            end
            S_ENQ_SCAN: begin
                if (back_lt) begin
                    // Drop the smaller tail entry and fetch the one before it.
                    dq_count_next = dq_count_reg - CNT_W'(1);
                    dq_rd_en      = (dq_count_reg > CNT_W'(1));
                    dq_rd_addr    = dq_head_reg + dq_prev_ofs[ADDR_W-1:0];
                end else if (out_free) begin
                    dq_wr_en      = 1'b1;
                    dq_count_next = dq_count_reg + CNT_W'(1);
                    back_next     = val_reg;
                    if (dq_count_reg == '0) begin
                        front_next = val_reg;
                    end
                    m_valid_next      = 1'b1;
                    m_data_out_next   = '0;
                    m_max_value_next  = (dq_count_reg == '0) ? val_reg : front_reg;
                    m_fill_count_next = count_reg;
                    m_status_next     = ST_DONE;
                end
            end
            S_ENQ_LOAD: begin
                back_next = dq_rd_data;
            end
            S_DEQ_DATA: begin
                if (out_free) begin
                    m_valid_next      = 1'b1;
                    m_data_out_next   = fifo_rd_data;
                    m_fill_count_next = count_reg;
                    m_status_next     = ST_DONE;
                    if (front_leaves) begin
                        dq_head_next     = dq_head_reg + ADDR_W'(1);
                        dq_count_next    = dq_count_reg - CNT_W'(1);
                        front_next       = dq_rd_data;
                        m_max_value_next = (dq_count_reg > CNT_W'(1)) ? dq_rd_data : '0;
                    end else begin
                        m_max_value_next = front_reg;
                    end
                end
            end
            default: begin
                m_valid_next = m_valid_reg && !m_ready;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            head_reg     <= '0;
            count_reg    <= '0;
            dq_head_reg  <= '0;
            dq_count_reg <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            head_reg     <= head_next;
            count_reg    <= count_next;
            dq_head_reg  <= dq_head_next;
            dq_count_reg <= dq_count_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        front_reg        <= front_next;
        back_reg         <= back_next;
        val_reg          <= val_next;
        status_reg       <= status_next;
        m_data_out_reg   <= m_data_out_next;
        m_max_value_reg  <= m_max_value_next;
        m_fill_count_reg <= m_fill_count_next;
        m_status_reg     <= m_status_next;
    end

    // Between requests the max deque is a subsequence of the queue contents.
    a_deque_within_queue: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_IDLE) |-> (dq_count_reg <= count_reg))
        else $error("max deque holds more entries than the queue");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(DEPTH))
        else $error("queue fill count beyond depth");

    a_deque_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_IDLE && count_reg != '0) |-> (dq_count_reg != '0))
        else $error("queue holds entries but max deque is empty");

    a_result_ends_request: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> (state_reg == S_IDLE))
        else $error("result issued while request still in progress");

endmodule
